// ----- design/flcrc_pkg.sv -----
package flcrc_pkg;

  // Reflected CRC32C (Castagnoli) polynomial
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  // Left rotations applied to lanes 0..3 and to the tail before folding
  localparam int unsigned ROT_LANE0 = 3;
  localparam int unsigned ROT_LANE1 = 5;
  localparam int unsigned ROT_LANE2 = 7;
  localparam int unsigned ROT_LANE3 = 11;
  localparam int unsigned ROT_TAIL  = 13;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTES_W   = 3;
  localparam int unsigned HELD_MAX  = 3;

  // One byte through the reflected CRC, eight bit steps, no inversion
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

// ----- design/four_lane_crc32c_hash_core.sv -----
// Four-lane CRC32C hash. A message arrives one 32-bit little-endian word per
// transaction; in_tuser marks the first word (clears the lanes and samples the
// seed) and in_tlast the final word, whose valid byte count may be 0..4.
// Every fourth word completes a group that runs through the four lanes, one
// byte per cycle in a single shared byte-wide CRC32C unit; any other
// non-final word is just stored in the held words. The final word then
// hashes the tail (up to 15 bytes, one byte per cycle, from the seed) and
// then folds lanes and tail into the digest, which waits in an output
// register until taken; the fold stalls while the previous digest is still
// held there. in_tready is high only while the sequencer is idle. The seed
// is kept across messages that lack a first mark.
module four_lane_crc32c_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // [31:0] data_word, [34:32] valid_bytes, [66:35] seed, rest 0
  input  logic        in_tuser,  // [0] first
  input  logic        in_tlast,  // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // [31:0] digest
);

  typedef enum logic [1:0] {ST_IDLE, ST_LANE, ST_TAIL, ST_DONE} state_t;

  state_t      state_r;
  logic [31:0] lane_r [4];
  logic [31:0] held_r [flcrc_pkg::HELD_MAX];
  logic [1:0]  held_cnt_r;
  logic [31:0] seed_r;
  logic [31:0] acc_r;
  logic [31:0] word_r;
  logic [2:0]  nb_r;
  logic        last_r;
  logic [1:0]  idx_r;    // lane index in ST_LANE, word index in ST_TAIL
  logic [1:0]  byte_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  // Input field unpacking
  logic [31:0] in_word;
  logic [2:0]  in_vb;
  logic [31:0] in_seed;
  logic        in_first;
  assign in_word  = in_tdata[31:0];
  assign in_vb    = in_tdata[34:32];
  assign in_seed  = in_tdata[66:35];
  assign in_first = in_tuser;

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Decisions for the word being accepted
  logic [2:0] nb_eff;
  logic [1:0] held_eff;
  logic       grp_done;
  assign nb_eff   = (!in_tlast || in_vb > 3'd4) ? 3'd4 : in_vb;
  assign held_eff = in_first ? 2'd0 : held_cnt_r;
  assign grp_done = (nb_eff == 3'd4) && (held_eff == 2'd3);

  // Word and CRC operand select for the shared unit
  logic [31:0] word_sel;
  logic [31:0] crc_in;
  logic [31:0] word_sh;
  logic [31:0] crc_out;
  always_comb begin
    word_sel = word_r;
    if (state_r == ST_LANE) begin
      if (idx_r != 2'd3) word_sel = held_r[idx_r];
    end else if (idx_r != held_cnt_r) begin
      word_sel = held_r[idx_r];
    end
  end
  assign crc_in  = (state_r == ST_LANE) ? lane_r[idx_r] : acc_r;
  assign word_sh = word_sel >> {byte_r, 3'b000};
  assign crc_out = flcrc_pkg::crc_byte(crc_in, word_sh[7:0]);

  // Tail bookkeeping
  logic       tail_cur;
  logic [1:0] tail_lim;   // last byte index of the word in work
  logic       out_free;
  assign tail_cur = (idx_r == held_cnt_r);
  assign tail_lim = tail_cur ? 2'(nb_r - 3'd1) : 2'd3;
  assign out_free = !out_tvalid_r || out_tready;

  // Folded digest
  logic [31:0] digest;
  assign digest = flcrc_pkg::rotl32(lane_r[0], flcrc_pkg::ROT_LANE0)
                ^ flcrc_pkg::rotl32(lane_r[1], flcrc_pkg::ROT_LANE1)
                ^ flcrc_pkg::rotl32(lane_r[2], flcrc_pkg::ROT_LANE2)
                ^ flcrc_pkg::rotl32(lane_r[3], flcrc_pkg::ROT_LANE3)
                ^ flcrc_pkg::rotl32(acc_r, flcrc_pkg::ROT_TAIL);

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      for (int i = 0; i < 4; i++) lane_r[i] <= '0;
      held_cnt_r   <= '0;
      seed_r       <= '0;
      idx_r        <= '0;
      byte_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // output valid: set by the fold, cleared when taken
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            word_r <= in_word;
            last_r <= in_tlast;
            idx_r  <= '0;
            byte_r <= '0;
            if (in_first) begin
              for (int i = 0; i < 4; i++) lane_r[i] <= '0;
              seed_r <= in_seed;
              acc_r  <= in_seed;
            end else begin
              acc_r  <= seed_r;
            end
            if (grp_done) begin
              nb_r       <= '0;
              held_cnt_r <= '0;
              state_r    <= ST_LANE;
            end else if (!in_tlast) begin
              held_r[held_eff] <= in_word;
              held_cnt_r       <= held_eff + 2'd1;
            end else begin
              nb_r       <= nb_eff;
              held_cnt_r <= held_eff;
              state_r    <= (held_eff == 2'd0 && nb_eff == 3'd0) ? ST_DONE : ST_TAIL;
            end
          end
        end
        ST_LANE: begin
          lane_r[idx_r] <= crc_out;
          byte_r        <= byte_r + 2'd1;
          if (byte_r == 2'd3) begin
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              state_r <= last_r ? ST_DONE : ST_IDLE;
            end
          end
        end
        ST_TAIL: begin
          acc_r <= crc_out;
          if (byte_r == tail_lim) begin
            byte_r <= '0;
            idx_r  <= idx_r + 2'd1;
            priority if (tail_cur) begin
              state_r <= ST_DONE;
            end else if ((idx_r + 2'd1) == held_cnt_r && nb_r == 3'd0) begin
              state_r <= ST_DONE;
            end
          end else begin
            byte_r <= byte_r + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_tdata_r  <= digest;
            for (int i = 0; i < 4; i++) lane_r[i] <= '0;
            held_cnt_r   <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A final word never leaves the sequencer idle on the next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> state_r != ST_IDLE)
    else $error("final word accepted but sequencer idle");

  // Folding the digest presents a result and empties the held words
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_tvalid_r && held_cnt_r == 2'd0)
    else $error("digest not presented after fold");

  // On a return to idle other than from the fold, the lane index has wrapped to zero
  a_lane_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && $past(state_r) != ST_IDLE && $past(rst_n) |-> idx_r == 2'd0
      || $past(state_r) == ST_DONE)
    else $error("index not wrapped on return to idle");

endmodule

// ----- test/four_lane_crc32c_hash_core_tb.sv -----
module four_lane_crc32c_hash_core_tb;

  localparam int NUM_WORDS   = 1400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 64;
  localparam int HOLD_CYCLES = 400;

  // One message word as offered on the input channel, plus an optional typed digest
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        first;
    logic        last;
    logic [31:0] seed;
    logic        known;
    logic [31:0] digest;
  } hash_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [31:0] data_word, [34:32] valid_bytes, [66:35] seed, rest 0
  logic        in_tuser;   // [0] first
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest

  // Typed digest travelling with the word, seen by the monitor at acceptance
  logic        row_known;
  logic [31:0] row_digest;

  // Predictor state
  logic [31:0] lane_sum [4];
  logic [31:0] held_word [3];
  int          held_n;
  logic [31:0] msg_seed;

  logic [31:0] digest_q [$];
  logic [31:0] pred_digest;

  int n_cycles;
  int n_sent;
  int n_words;
  int n_msgs;
  int n_checked;
  int n_errors;
  int cur_stall;
  int max_stall;
  int burst_left;

  four_lane_crc32c_hash_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed words: reset state, seed extremes, group completion, long tail,
  // ignored byte counts, seed carried over, restart mid-message
  hash_word_t dir_rows [25] = '{
    '{32'h0000_005A, 3'd1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 32'h0000_2000},
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 32'h0000_1000},
    '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'hDEAD_BEEF, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1234_5678, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h8000_0001, 3'd4, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0302_0100, 3'd4, 1'b1, 1'b0, 32'h0000_FFFF, 1'b0, 32'h0},
    '{32'h0706_0504, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0B0A_0908, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0F0E_0D0C, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1312_1110, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1716_1514, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1B1A_1918, 3'd4, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1F1E_1D1C, 3'd3, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hA5A5_A5A5, 3'd1, 1'b1, 1'b0, 32'h1234_5678, 1'b0, 32'h0},
    '{32'h5A5A_5A5A, 3'd7, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hC3C3_C3C3, 3'd2, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h0000_0000, 3'd5, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
    '{32'h1111_1111, 3'd4, 1'b1, 1'b0, 32'h0F0F_0F0F, 1'b0, 32'h0},
    '{32'h2222_2222, 3'd0, 1'b1, 1'b1, 32'hF0F0_F0F0, 1'b0, 32'h0}
  };

  // Reflected CRC32C over one byte, bit-serial, no inversion
  function automatic logic [31:0] crc32c_byte_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      fb = r[0];
      r = {1'b0, r[31:1]};
      if (fb) r = r ^ flcrc_pkg::CRC_POLY;
    end
    return r;
  endfunction

  // First n bytes of a word, low byte first
  function automatic logic [31:0] crc32c_word(input logic [31:0] c, input logic [31:0] w,
                                              input int n);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < n; i++) r = crc32c_byte_step(r, w[8*i +: 8]);
    return r;
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

  // Advances the hash state by one word; returns 1 when a digest falls out
  function automatic bit hash_step(input logic [31:0] w, input logic [2:0] vb, input logic first,
                                   input logic last, input logic [31:0] seed,
                                   output logic [31:0] digest);
    int          nb;
    logic [31:0] tail;
    digest = '0;
    if (first) begin
      for (int i = 0; i < 4; i++) lane_sum[i] = '0;
      held_n   = 0;
      msg_seed = seed;
    end
    nb = (vb > 3'd4 || !last) ? 4 : int'(vb);

    // fourth word of a group goes through the lanes
    if (nb == 4 && held_n == flcrc_pkg::HELD_MAX) begin
      for (int i = 0; i < 3; i++) lane_sum[i] = crc32c_word(lane_sum[i], held_word[i], 4);
      lane_sum[3] = crc32c_word(lane_sum[3], w, 4);
      held_n = 0;
      nb     = 0;
    end else if (!last) begin
      held_word[held_n] = w;
      held_n++;
    end
    if (!last) return 1'b0;

    // tail from the seed, then fold
    tail = msg_seed;
    for (int i = 0; i < held_n; i++) tail = crc32c_word(tail, held_word[i], 4);
    tail = crc32c_word(tail, w, nb);
    digest = rol32(lane_sum[0], flcrc_pkg::ROT_LANE0) ^
             rol32(lane_sum[1], flcrc_pkg::ROT_LANE1) ^
             rol32(lane_sum[2], flcrc_pkg::ROT_LANE2) ^
             rol32(lane_sum[3], flcrc_pkg::ROT_LANE3) ^
             rol32(tail, flcrc_pkg::ROT_TAIL);
    for (int i = 0; i < 4; i++) lane_sum[i] = '0;
    held_n = 0;
    return 1'b1;
  endfunction

  task automatic report_error(input string msg);
    n_errors++;
    $display("ERROR @%0d: %s", n_cycles, msg);
  endtask

  // Presents one word after a random gap and waits for its transaction
  task automatic drive_word(input hash_word_t w);
    int gap;
    int r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
    end else if (r < 5) begin
      burst_left = $urandom_range(20, 60);
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {5'd0, w.seed, w.nbytes, w.word};
    in_tuser   <= w.first;
    in_tlast   <= w.last;
    row_known  <= w.known;
    row_digest <= w.digest;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'h0000_0000;
    if (r < 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Well-formed message with random content; a few lack the first mark or restart
  task automatic send_random_message();
    hash_word_t w;
    int         len;
    int         r;
    bit         marked;
    logic [31:0] seed;
    r = $urandom_range(0, 99);
    if (r < 70)      len = $urandom_range(0, 7);
    else if (r < 95) len = $urandom_range(8, 20);
    else             len = $urandom_range(21, 48);
    marked = ($urandom_range(0, 99) < 90);
    seed   = rand_word();
    for (int i = 0; i <= len; i++) begin
      w.word   = rand_word();
      w.first  = (marked && i == 0) || ($urandom_range(0, 99) < 2);
      w.last   = (i == len);
      w.seed   = w.first ? seed : rand_word();
      w.known  = 1'b0;
      w.digest = '0;
      if (w.last) begin
        w.nbytes = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                : 3'($urandom_range(5, 7));
      end else begin
        w.nbytes = ($urandom_range(0, 99) < 85) ? 3'd4 : 3'($urandom_range(0, 7));
      end
      drive_word(w);
    end
  endtask

  // Cycle counter and timeout
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input monitor, predictor and output checker
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) lane_sum[i] = '0;
      for (int i = 0; i < 3; i++) held_word[i] = '0;
      held_n   = 0;
      msg_seed = '0;
    end else begin
      if (in_tvalid && !in_tready) begin
        cur_stall++;
        if (cur_stall > max_stall) max_stall = cur_stall;
      end else begin
        cur_stall = 0;
      end

      // input transaction
      if (in_tvalid && in_tready) begin
        n_words++;
        if (hash_step(in_tdata[31:0], in_tdata[34:32], in_tuser, in_tlast,
                      in_tdata[66:35], pred_digest)) begin
          n_msgs++;
          digest_q = {digest_q, (row_known ? row_digest : pred_digest)};
        end
      end

      // output transaction
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          report_error($sformatf("unexpected digest %08h", out_tdata));
        end else begin
          n_checked++;
          if (out_tdata !== digest_q[0])
            report_error($sformatf("digest %08h, expected %08h", out_tdata, digest_q[0]));
          void'(digest_q.pop_front());
        end
      end
    end
  end

  // Receiver: random ready runs, plus two long hold-offs while words keep coming
  initial begin
    int  r;
    int  n;
    bit  hold_a;
    bit  hold_b;
    hold_a = 1'b0;
    hold_b = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_a && n_words >= 150) begin
        hold_a = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!hold_b && n_words >= 900) begin
        hold_b = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready <= 1'b1;
          n = $urandom_range(1, 30);
        end else if (r < 95) begin
          out_tready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          n = $urandom_range(10, 60);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    n_cycles   = 0;
    n_sent     = 0;
    n_words    = 0;
    n_msgs     = 0;
    n_checked  = 0;
    n_errors   = 0;
    cur_stall  = 0;
    max_stall  = 0;
    burst_left = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    row_known  <= 1'b0;
    row_digest <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_word(dir_rows[i]);
    while (n_sent < NUM_WORDS) send_random_message();
    in_tvalid <= 1'b0;

    // let the monitor record the final transaction before draining
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("hashed %0d words in %0d messages, %0d digests checked, %0d errors",
             n_words, n_msgs, n_checked, n_errors);
    $display("longest input stall under output back-pressure: %0d cycles", max_stall);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
